// ===== design/vis_pkg.sv =====
`default_nettype none

package vis_pkg;

  // Widths of the fields seen at the ports
  localparam int unsigned MaskW  = 11;
  localparam int unsigned BankW  = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IndexW = 16;
  localparam int unsigned CycleW = 32;

  // Defaults for the top level parameters
  localparam int unsigned DefIndexBits = 16;
  localparam int unsigned DefDmaBanks  = 4;

  // PU slot kinds
  localparam logic [KindW-1:0] KindNone   = 2'd0;
  localparam logic [KindW-1:0] KindMatrix = 2'd1;
  localparam logic [KindW-1:0] KindVector = 2'd2;
  localparam logic [KindW-1:0] KindScalar = 2'd3;

  typedef enum logic [1:0] {
    ACT_IDLE     = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_SYNC     = 2'd2,
    ACT_STRUCT   = 2'd3
  } vis_action_e;

  typedef struct packed {
    logic             sdma;
    logic             idma;
    logic [KindW-1:0] pu0;
    logic [KindW-1:0] pu1;
  } vis_start_t;

endpackage

`default_nettype wire

// ===== design/vis_issue_logic.sv =====
`default_nettype none

module vis_issue_logic #(
  parameter  int unsigned DMA_BANKS = vis_pkg::DefDmaBanks,
  localparam int unsigned BusyW     = 7 + DMA_BANKS
) (
  input  wire logic [BusyW-1:0]         busy_i,
  input  wire logic                     packet_present_i,
  input  wire logic                     sdma_request_i,
  input  wire logic                     idma_request_i,
  input  wire logic [vis_pkg::BankW-1:0] idma_bank_i,
  input  wire logic [vis_pkg::KindW-1:0] pu0_kind_i,
  input  wire logic [vis_pkg::KindW-1:0] pu1_kind_i,
  input  wire logic [BusyW-1:0]         wait_mask_i,
  input  wire logic [BusyW-1:0]         done_mask_i,
  output vis_pkg::vis_action_e          action_o,
  output logic      [BusyW-1:0]         busy_o,
  output vis_pkg::vis_start_t           start_o
);
  import vis_pkg::*;

  localparam int unsigned Pu0Base = 1 + DMA_BANKS;
  localparam int unsigned Pu1Base = 4 + DMA_BANKS;

  logic [BusyW-1:0] busy_clr;
  logic [BusyW-1:0] busy_set;
  logic             sdma_busy, idma_busy, pu0_busy, pu1_busy;
  logic             structural, wait_block, idma_hit;

  assign busy_clr  = busy_i & ~done_mask_i;
  assign sdma_busy = busy_clr[0];
  assign idma_busy = |busy_clr[DMA_BANKS:1];
  assign pu0_busy  = |busy_clr[Pu0Base +: 3];
  assign pu1_busy  = |busy_clr[Pu1Base +: 3];

  assign wait_block = |(wait_mask_i & busy_clr);
  assign structural = (sdma_request_i && sdma_busy) ||
                      (idma_request_i && idma_busy) ||
                      (pu0_kind_i != KindNone && pu0_busy) ||
                      (pu1_kind_i != KindNone && pu1_busy);

  // Bits that a dispatch would set; a bank beyond the last one sets none
  always_comb begin
    busy_set    = '0;
    busy_set[0] = sdma_request_i;
    for (int b = 0; b < int'(DMA_BANKS); b++) begin
      busy_set[1 + b] = idma_request_i && (idma_bank_i == BankW'(b));
    end
    busy_set[Pu0Base]     = (pu0_kind_i == KindMatrix);
    busy_set[Pu0Base + 1] = (pu0_kind_i == KindVector);
    busy_set[Pu0Base + 2] = (pu0_kind_i == KindScalar);
    busy_set[Pu1Base]     = (pu1_kind_i == KindMatrix);
    busy_set[Pu1Base + 1] = (pu1_kind_i == KindVector);
    busy_set[Pu1Base + 2] = (pu1_kind_i == KindScalar);
  end

  assign idma_hit = |busy_set[DMA_BANKS:1];

  always_comb begin
    action_o = ACT_IDLE;
    busy_o   = busy_clr;
    start_o  = '0;
    if (packet_present_i) begin
      if (wait_block) begin
        action_o = ACT_SYNC;
      end else if (structural) begin
        action_o = ACT_STRUCT;
      end else begin
        action_o     = ACT_DISPATCH;
        busy_o       = busy_clr | busy_set;
        start_o.sdma = sdma_request_i;
        start_o.idma = idma_hit;
        start_o.pu0  = pu0_kind_i;
        start_o.pu1  = pu1_kind_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/vliw_issue_scoreboard.sv =====
// A transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless a result waits on out_ready_i; the two
// registers form a two-deep pipeline, the issue decision is one pass of logic between
// them. Busy register and tick counter update as a transaction leaves the input register,
// the index only on dispatch. Reset clears busy bits, index, tick count, both valid flags.
`default_nettype none

module vliw_issue_scoreboard #(
  parameter int unsigned INDEX_BITS = vis_pkg::DefIndexBits,
  parameter int unsigned DMA_BANKS  = vis_pkg::DefDmaBanks
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      packet_present_i,
  input  wire logic                      sdma_request_i,
  input  wire logic                      idma_request_i,
  input  wire logic [vis_pkg::BankW-1:0] idma_bank_i,
  input  wire logic [vis_pkg::KindW-1:0] pu0_kind_i,
  input  wire logic [vis_pkg::KindW-1:0] pu1_kind_i,
  input  wire logic [vis_pkg::MaskW-1:0] wait_mask_i,
  input  wire logic [vis_pkg::MaskW-1:0] done_mask_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     issue_action_o,
  output logic [vis_pkg::MaskW-1:0]      busy_out_o,
  output logic                           sdma_start_o,
  output logic                           idma_start_o,
  output logic [vis_pkg::KindW-1:0]      pu0_start_o,
  output logic [vis_pkg::KindW-1:0]      pu1_start_o,
  output logic [vis_pkg::IndexW-1:0]     issued_index_o,
  output logic [vis_pkg::CycleW-1:0]     cycle_number_o
);
  import vis_pkg::*;

  localparam int unsigned BusyW = 7 + DMA_BANKS;

  // Input register
  logic             s1_valid_q;
  logic             present_q, sreq_q, ireq_q;
  logic [BankW-1:0] bank_q;
  logic [KindW-1:0] k0_q, k1_q;
  logic [MaskW-1:0] wait_q, done_q;

  // Scoreboard state
  logic [BusyW-1:0]      busy_q;
  logic [INDEX_BITS-1:0] ptr_q;
  logic [CycleW-1:0]     tick_q;

  // Result register
  logic              out_valid_q;
  vis_action_e       action_q;
  logic [MaskW-1:0]  busy_out_q;
  vis_start_t        start_q;
  logic [IndexW-1:0] index_q;
  logic [CycleW-1:0] cycle_q;

  logic             s1_fire;
  vis_action_e      dec_action;
  logic [BusyW-1:0] dec_busy;
  vis_start_t       dec_start;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  vis_issue_logic #(
    .DMA_BANKS (DMA_BANKS)
  ) u_issue (
    .busy_i           (busy_q),
    .packet_present_i (present_q),
    .sdma_request_i   (sreq_q),
    .idma_request_i   (ireq_q),
    .idma_bank_i      (bank_q),
    .pu0_kind_i       (k0_q),
    .pu1_kind_i       (k1_q),
    .wait_mask_i      (BusyW'(wait_q)),
    .done_mask_i      (BusyW'(done_q)),
    .action_o         (dec_action),
    .busy_o           (dec_busy),
    .start_o          (dec_start)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      busy_q      <= '0;
      ptr_q       <= '0;
      tick_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        busy_q <= dec_busy;
        tick_q <= tick_q + 1'b1;
        if (dec_action == ACT_DISPATCH) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      present_q <= packet_present_i;
      sreq_q    <= sdma_request_i;
      ireq_q    <= idma_request_i;
      bank_q    <= idma_bank_i;
      k0_q      <= pu0_kind_i;
      k1_q      <= pu1_kind_i;
      wait_q    <= wait_mask_i;
      done_q    <= done_mask_i;
    end
    if (s1_fire) begin
      action_q   <= dec_action;
      busy_out_q <= MaskW'(dec_busy);
      start_q    <= dec_start;
      index_q    <= IndexW'(ptr_q);
      cycle_q    <= tick_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign issue_action_o = action_q;
  assign busy_out_o     = busy_out_q;
  assign sdma_start_o   = start_q.sdma;
  assign idma_start_o   = start_q.idma;
  assign pu0_start_o    = start_q.pu0;
  assign pu1_start_o    = start_q.pu1;
  assign issued_index_o = index_q;
  assign cycle_number_o = cycle_q;

  // Strobes only go out with a dispatch
  a_start_only_on_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q != ACT_DISPATCH) |-> (start_q == '0))
    else $error("start strobe without dispatch");

  // Index holds unless the packet dispatched
  a_ptr_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && dec_action != ACT_DISPATCH) |=> (ptr_q == $past(ptr_q)))
    else $error("packet index moved without dispatch");

  // One tick per processed transaction
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (tick_q == $past(tick_q) + 1'b1))
    else $error("tick count out of step");

  // A started sDMA engine shows busy in the same result
  a_sdma_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && start_q.sdma) |-> busy_out_q[0])
    else $error("sDMA started but not busy");

  // Idle ticks never set busy bits
  a_idle_no_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !present_q) |=> ((busy_q & ~$past(busy_q)) == '0))
    else $error("busy bit set on idle tick");

endmodule

`default_nettype wire
